// File: design/psrl_pkg.sv
`default_nettype none

package psrl_pkg;

  localparam int BUCKET_COUNT = 1024;
  localparam int PROBE_DEPTH  = 8;
  localparam int IDX_W        = $clog2(BUCKET_COUNT);
  localparam int PC_W         = $clog2(PROBE_DEPTH + 1);

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  localparam logic [15:0] OPEN_LIMIT_RST    = 16'd20;
  localparam logic [15:0] ECHO_LIMIT_RST    = 16'd60;
  localparam logic [15:0] WINDOW_LENGTH_RST = 16'd1000;

  localparam logic [1:0] MODE_OPEN  = 2'd0;
  localparam logic [1:0] MODE_PING  = 2'd1;
  localparam logic [1:0] MODE_ECHO  = 2'd2;
  localparam logic [1:0] MODE_OTHER = 2'd3;

  localparam logic [1:0] CFG_OPEN_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_ECHO_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd2;

  typedef struct packed {
    logic [31:0] addr;
    logic [47:0] start;
    logic [15:0] opens;
    logic [15:0] pings;
    logic [15:0] echoes;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } tbl_req_t;

endpackage

`default_nettype wire

// File: design/psrl_table.sv
`default_nettype none

module psrl_table (
  input  wire logic              clk,
  input  wire psrl_pkg::tbl_req_t req,
  output psrl_pkg::entry_t        rd_data
);

  psrl_pkg::entry_t mem [psrl_pkg::BUCKET_COUNT];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/per_source_rate_limiter_unit.sv
`default_nettype none

// Per-source rate limiter. After reset the block clears its 1024-entry bucket
// table, one entry a cycle, and holds in_ready low until the clear is done.
// Items of kind other go from acceptance straight to result load. A limited
// item runs these steps before in_ready returns: the hash multiply is taken
// at acceptance, then a setup state, then probing through the table's single
// read port (one slot read a cycle, each read checked in the cycle after it),
// then window check, write-back and result load. Items enter one at a time;
// a waiting result is held in the output register while the next item runs,
// and that item stalls at result load until the waiting result has left.
module per_source_rate_limiter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] source_addr,
  input  wire logic [1:0]  mode,
  input  wire logic [47:0] now_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             allow,
  output logic [31:0]      drops_total
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_STALE = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  localparam int IDX_W = psrl_pkg::IDX_W;
  localparam int PC_W  = psrl_pkg::PC_W;

  logic [2:0]  state;
  logic [15:0] open_limit;
  logic [15:0] echo_limit;
  logic [15:0] window_length;
  logic [31:0] drop_counter;

  logic [IDX_W-1:0] clr_idx;
  logic [31:0]      addr;
  logic [1:0]       kind;
  logic [47:0]      now;
  logic [IDX_W-1:0] home;
  logic [PC_W-1:0]  rd_cnt;
  logic [PC_W-1:0]  chk_cnt;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_slot;
  logic [47:0]      oldest;
  psrl_pkg::entry_t evict_entry;
  logic [IDX_W-1:0] evict_slot;
  psrl_pkg::entry_t sel_entry;
  logic [IDX_W-1:0] sel_slot;
  logic             stale;
  logic             ok;

  psrl_pkg::tbl_req_t tbl_req;
  psrl_pkg::entry_t   rd_data;

  psrl_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (rd_data)
  );

  logic             issue;
  logic [IDX_W-1:0] issue_slot;
  logic             evict_take;
  logic             hit;
  logic             last_chk;
  logic [31:0]      hash;
  logic [47:0]      age;
  psrl_pkg::entry_t base;
  logic [15:0]      cur_cnt;
  logic [15:0]      cur_limit;
  logic             over;
  psrl_pkg::entry_t upd;

  assign in_ready   = (state == ST_IDLE);
  assign issue      = (state == ST_PROBE) && (rd_cnt < PC_W'(psrl_pkg::PROBE_DEPTH));
  assign issue_slot = home + IDX_W'(rd_cnt);
  assign evict_take = (chk_cnt == '0) || (rd_data.start < oldest);
  assign hit        = (rd_data.addr == addr) || (rd_data.addr == '0 && rd_data.start == '0);
  assign last_chk   = (chk_cnt == PC_W'(psrl_pkg::PROBE_DEPTH - 1));
  assign hash       = 32'(source_addr * psrl_pkg::HASH_MULT);
  assign age        = now - sel_entry.start;

  always_comb begin
    base = sel_entry;
    if (stale) begin
      base = '{addr: addr, start: now, opens: '0, pings: '0, echoes: '0};
    end
    unique case (kind)
      psrl_pkg::MODE_OPEN: cur_cnt = base.opens;
      psrl_pkg::MODE_PING: cur_cnt = base.pings;
      default:             cur_cnt = base.echoes;
    endcase
    cur_limit = (kind == psrl_pkg::MODE_OPEN) ? open_limit : echo_limit;
    over      = (cur_cnt >= cur_limit);
    upd       = base;
    if (!over) begin
      unique case (kind)
        psrl_pkg::MODE_OPEN: upd.opens  = cur_cnt + 16'd1;
        psrl_pkg::MODE_PING: upd.pings  = cur_cnt + 16'd1;
        default:             upd.echoes = cur_cnt + 16'd1;
      endcase
    end
  end

  always_comb begin
    tbl_req         = '0;
    tbl_req.rd_en   = issue;
    tbl_req.rd_addr = issue_slot;
    if (state == ST_CLEAR) begin
      tbl_req.wr_en   = 1'b1;
      tbl_req.wr_addr = clr_idx;
    end else if (state == ST_WRITE) begin
      tbl_req.wr_en   = 1'b1;
      tbl_req.wr_addr = sel_slot;
      tbl_req.wr_data = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_limit <= psrl_pkg::OPEN_LIMIT_RST;
      echo_limit <= psrl_pkg::ECHO_LIMIT_RST;
      window_length <= psrl_pkg::WINDOW_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        psrl_pkg::CFG_OPEN_LIMIT:    open_limit <= cfg_data;
        psrl_pkg::CFG_ECHO_LIMIT:    echo_limit <= cfg_data;
        psrl_pkg::CFG_WINDOW_LENGTH: window_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      drop_counter <= '0;
      chk_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      chk_valid <= issue;
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            addr <= source_addr;
            kind <= mode;
            now  <= now_ms;
            home <= hash[31 -: IDX_W];
            ok   <= 1'b1;
            state <= (mode == psrl_pkg::MODE_OTHER) ? ST_FIN : ST_HASH;
          end
        end
        ST_HASH: begin
          rd_cnt <= '0;
          state  <= ST_PROBE;
        end
        ST_PROBE: begin
          if (issue) begin
            rd_cnt   <= rd_cnt + 1'b1;
            chk_cnt  <= rd_cnt;
            chk_slot <= issue_slot;
          end
          if (chk_valid) begin
            if (evict_take) begin
              oldest      <= rd_data.start;
              evict_entry <= rd_data;
              evict_slot  <= chk_slot;
            end
            if (hit) begin
              sel_entry <= rd_data;
              sel_slot  <= chk_slot;
              state     <= ST_STALE;
            end else if (last_chk) begin
              sel_entry <= evict_take ? rd_data : evict_entry;
              sel_slot  <= evict_take ? chk_slot : evict_slot;
              state     <= ST_STALE;
            end
          end
        end
        ST_STALE: begin
          stale <= (sel_entry.addr != addr) || (age >= {32'd0, window_length});
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (over) begin
            ok           <= 1'b0;
            drop_counter <= drop_counter + 32'd1;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            allow       <= ok;
            drops_total <= drop_counter;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/psrl_checker.sv
`default_nettype none

module psrl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  mode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        allow,
  input wire logic [31:0] drops_total
);

  // table clear keeps input closed after reset
  a_clear_busy: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input open right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input open while an item is in work");

  a_other_passes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode == psrl_pkg::MODE_OTHER && !out_valid)
      |=> ##1 (out_valid && allow))
    else $error("other-kind item not passed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(allow) && $stable(drops_total)))
    else $error("stalled result changed");

endmodule

bind per_source_rate_limiter_unit psrl_checker u_psrl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .mode        (mode),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .allow       (allow),
  .drops_total (drops_total)
);

`default_nettype wire

// File: verif/per_source_rate_limiter_unit_tb.sv
module per_source_rate_limiter_unit_tb;
  import psrl_pkg::*;

  localparam int STALL_LIMIT = 6000;

  typedef struct packed {
    logic        allow;
    logic [31:0] drops;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_OPEN_LIMIT;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] source_addr = 32'd0;
  logic [1:0]  mode = MODE_OTHER;
  logic [47:0] now_ms = 48'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        allow;
  logic [31:0] drops_total;

  per_source_rate_limiter_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .source_addr (source_addr),
    .mode        (mode),
    .now_ms      (now_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .allow       (allow),
    .drops_total (drops_total)
  );

  always #6 clk = ~clk;

  // shadow of the bucket table and limits
  entry_t      buckets [BUCKET_COUNT];
  logic [31:0] drop_count = 32'd0;
  logic [15:0] lim_open = OPEN_LIMIT_RST;
  logic [15:0] lim_echo = ECHO_LIMIT_RST;
  logic [15:0] win_len = WINDOW_LENGTH_RST;

  verdict_t    pending_verdicts [$];
  verdict_t    want;
  int          mismatches = 0;
  int          idle_cycles = 0;

  logic [31:0] hash_inv;
  logic [31:0] addr_pool [$];
  logic [47:0] clock_ms = 48'd0;
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  int          hold_req = 0;
  int          rx_stall_left = 0;
  int          rx_roll;

  function automatic verdict_t predict_admission(input logic [31:0] addr,
                                                 input logic [1:0] kind,
                                                 input logic [47:0] stamp);
    verdict_t         v;
    logic [31:0]      hash;
    logic [IDX_W-1:0] home;
    logic [IDX_W-1:0] probe;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] victim;
    logic [48:0]      oldest;
    logic [47:0]      age;
    logic             found;
    logic [15:0]      cnt;
    logic [15:0]      lim;
    v.allow = 1'b1;
    if (kind != MODE_OTHER) begin
      hash = addr * HASH_MULT;
      home = hash[31 -: IDX_W];
      victim = home;
      slot = home;
      oldest = '1;
      found = 1'b0;
      for (int i = 0; i < PROBE_DEPTH; i++) begin
        if (!found) begin
          probe = home + IDX_W'(i);
          if ({1'b0, buckets[probe].start} < oldest) begin
            oldest = {1'b0, buckets[probe].start};
            victim = probe;
          end
          if (buckets[probe].addr == addr ||
              (buckets[probe].addr == '0 && buckets[probe].start == '0)) begin
            found = 1'b1;
            slot = probe;
          end
        end
      end
      if (!found) slot = victim;
      age = stamp - buckets[slot].start;
      if (buckets[slot].addr != addr || age >= {32'd0, win_len}) begin
        buckets[slot].addr = addr;
        buckets[slot].start = stamp;
        buckets[slot].opens = '0;
        buckets[slot].pings = '0;
        buckets[slot].echoes = '0;
      end
      case (kind)
        MODE_OPEN: begin
          cnt = buckets[slot].opens;
          lim = lim_open;
        end
        MODE_PING: begin
          cnt = buckets[slot].pings;
          lim = lim_echo;
        end
        default: begin
          cnt = buckets[slot].echoes;
          lim = lim_echo;
        end
      endcase
      if (cnt >= lim) begin
        v.allow = 1'b0;
        drop_count = drop_count + 32'd1;
      end else begin
        cnt = cnt + 16'd1;
        case (kind)
          MODE_OPEN: buckets[slot].opens = cnt;
          MODE_PING: buckets[slot].pings = cnt;
          default:   buckets[slot].echoes = cnt;
        endcase
      end
    end
    v.drops = drop_count;
    return v;
  endfunction

  // address whose hash lands on a chosen home slot
  function automatic logic [31:0] slot_addr(input logic [IDX_W-1:0] home,
                                            input logic [31:0] salt);
    logic [31:0] h;
    h = {home, salt[31-IDX_W:0]};
    return h * hash_inv;
  endfunction

  function automatic void build_pool(input int homes, input int per_home);
    logic [IDX_W-1:0] home;
    addr_pool.delete();
    for (int h = 0; h < homes; h++) begin
      if (h == 0) home = IDX_W'(BUCKET_COUNT - 1 - $urandom_range(0, 6));
      else home = IDX_W'($urandom_range(0, BUCKET_COUNT - 1));
      for (int k = 0; k < per_home; k++) addr_pool.push_back(slot_addr(home, $urandom));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: result with no item pending: allow %0b drops_total %0d",
                   $time, allow, drops_total);
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          if (allow !== want.allow) begin
            $display("%0t: allow expected %0b actual %0b", $time, want.allow, allow);
            mismatches++;
          end
          if (drops_total !== want.drops) begin
            $display("%0t: drops_total expected %0d actual %0d",
                     $time, want.drops, drops_total);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_verdicts.push_back(predict_admission(source_addr, mode, now_ms));
    end
  end

  always @(posedge clk) begin
    if (hold_req > 0) begin
      rx_stall_left = hold_req;
      hold_req = 0;
    end
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else if (!rx_stalls) begin
      out_ready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 75) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_stall_left = (rx_roll < 96) ? $urandom_range(0, 2) : $urandom_range(14, 49);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [31:0] addr, input logic [1:0] kind,
                           input logic [47:0] stamp);
    int gap;
    int roll;
    in_valid <= 1'b1;
    source_addr <= addr;
    mode <= kind;
    now_ms <= stamp;
    do @(posedge clk); while (!in_ready);
    roll = $urandom_range(0, 99);
    if (!tx_gaps || roll < 55) gap = 0;
    else if (roll < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic load_limits(input logic [15:0] open_lim, input logic [15:0] echo_lim,
                             input logic [15:0] window);
    cfg_write <= 1'b1;
    cfg_index <= CFG_OPEN_LIMIT;
    cfg_data <= open_lim;
    @(posedge clk);
    cfg_index <= CFG_ECHO_LIMIT;
    cfg_data <= echo_lim;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_LENGTH;
    cfg_data <= window;
    @(posedge clk);
    cfg_write <= 1'b0;
    lim_open = open_lim;
    lim_echo = echo_lim;
    win_len = window;
  endtask

  task automatic run_traffic(input int count);
    logic [31:0] addr;
    logic [1:0]  kind;
    int          roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll >= 97) clock_ms = 48'({$urandom, $urandom});
      else if (roll >= 85)
        clock_ms += 48'($urandom_range(32'(win_len) / 2, 32'(win_len) + 32'(win_len) / 2));
      else if (roll >= 40) clock_ms += 48'($urandom_range(1, 32'(win_len) / 8 + 1));
      roll = $urandom_range(0, 99);
      if (roll < 85) addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
      else addr = $urandom;
      roll = $urandom_range(0, 9);
      kind = (roll < 3) ? MODE_OPEN : (roll < 6) ? MODE_PING :
             (roll < 9) ? MODE_ECHO : MODE_OTHER;
      send_item(addr, kind, clock_ms);
    end
  endtask

  task automatic test_basic_kinds();
    send_item(32'hFFFF_FFFF, MODE_OPEN, 48'hFFFF_FFFF_FFFF);
    send_item(32'hFFFF_FFFF, MODE_PING, 48'hFFFF_FFFF_FFFF);
    send_item(32'hFFFF_FFFF, MODE_ECHO, 48'h0);
    send_item(32'h8000_0001, MODE_OTHER, 48'h8000_0000_0000);
    send_item(32'h1234_5678, MODE_OPEN, 48'h1);
  endtask

  // address zero at time zero leaves its slot looking empty
  task automatic test_empty_slot();
    send_item(32'h0, MODE_OPEN, 48'h0);
    send_item(slot_addr(IDX_W'(0), 32'h155), MODE_OPEN, 48'h0);
    send_item(32'h0, MODE_PING, 48'h0);
  endtask

  task automatic test_window_wrap();
    logic [31:0] a;
    a = slot_addr(IDX_W'(300), 32'h7);
    send_item(a, MODE_OPEN, 48'hFFFF_FFFF_FFFB);
    send_item(a, MODE_OPEN, 48'd10);
    send_item(a, MODE_OPEN, 48'd995);
  endtask

  // full probe run; ties on window start evict the first of them
  task automatic test_eviction();
    send_item(slot_addr(IDX_W'(1000), 32'h1), MODE_ECHO, 48'd6000);
    for (int k = 2; k <= 8; k++) send_item(slot_addr(IDX_W'(1000), k), MODE_ECHO, 48'd5000);
    send_item(slot_addr(IDX_W'(1000), 32'h9), MODE_ECHO, 48'd6000);
  endtask

  task automatic test_tight_limits();
    wait_drained();
    load_limits(16'd1, 16'd1, 16'd1);
    send_item(32'hC0A8_0001, MODE_OPEN, 48'd7000);
    send_item(32'hC0A8_0001, MODE_OPEN, 48'd7000);
    send_item(32'hC0A8_0001, MODE_PING, 48'd7000);
    send_item(32'hC0A8_0001, MODE_PING, 48'd7000);
    send_item(32'hC0A8_0001, MODE_ECHO, 48'd7000);
    send_item(32'hC0A8_0001, MODE_ECHO, 48'd7000);
    send_item(32'hC0A8_0001, MODE_OPEN, 48'd7001);
    clock_ms = 48'd10000;
    build_pool(2, 3);
    run_traffic(150);
  endtask

  task automatic test_wide_limits();
    wait_drained();
    load_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
    clock_ms = 48'hFFFF_FFFF_FFFF - 48'd200000;
    build_pool(3, 10);
    run_traffic(200);
  endtask

  task automatic test_small_windows();
    wait_drained();
    load_limits(16'($urandom_range(2, 8)), 16'($urandom_range(2, 8)),
                16'($urandom_range(5, 300)));
    build_pool(2, 5);
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    run_traffic(120);
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    run_traffic(130);
  endtask

  task automatic test_backpressure();
    wait_drained();
    load_limits(OPEN_LIMIT_RST, ECHO_LIMIT_RST, WINDOW_LENGTH_RST);
    build_pool(1, 4);
    tx_gaps = 1'b0;
    hold_req = 400;
    run_traffic(30);
    wait_drained();
    tx_gaps = 1'b1;
    build_pool(4, 12);
    run_traffic(300);
  endtask

  task automatic test_mixed();
    wait_drained();
    load_limits(16'($urandom_range(3, 40)), 16'($urandom_range(3, 40)),
                16'($urandom_range(50, 3000)));
    build_pool(3, 6);
    run_traffic(170);
  endtask

  initial begin
    hash_inv = HASH_MULT;
    repeat (5) hash_inv = hash_inv * (32'd2 - HASH_MULT * hash_inv);
    for (int i = 0; i < BUCKET_COUNT; i++) buckets[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_basic_kinds();
    test_empty_slot();
    test_window_wrap();
    test_eviction();
    test_tight_limits();
    test_wide_limits();
    test_small_windows();
    test_backpressure();
    test_mixed();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/psrl_pkg.sv
design/psrl_table.sv
design/per_source_rate_limiter_unit.sv
design/psrl_checker.sv
verif/per_source_rate_limiter_unit_tb.sv
